@@ hdl/mwp_pkg.sv @@
// ----------------------------------------------------------------------------
// mwp_pkg: shared types and constants for the window predictor
// Sequencer states, codes and the elaborated sigmoid lookup table.
// ----------------------------------------------------------------------------
package mwp_pkg;

    localparam int SIG_DEPTH   = 256;
    localparam int SIG_IDX_W   = 8;
    localparam int ACC_W       = 40;
    localparam int SAMPLE_W    = 16;
    localparam int RECIP_W     = 33;
    localparam int CFG_IDX_W   = 2;
    localparam int MUL_A_W     = 18;
    localparam int MUL_B_W     = 34;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;

    localparam logic [1:0] KIND_LOAD    = 2'd0;
    localparam logic [1:0] KIND_PUSH    = 2'd1;
    localparam logic [1:0] KIND_PREDICT = 2'd2;
    localparam logic [1:0] KIND_UNUSED  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_PRICE_MIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRICE_SPAN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN_RECIP = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NORM_MUL,
        ST_NORM_SAT,
        ST_W_READ,
        ST_W_MUL,
        ST_W_ACC,
        ST_B_READ,
        ST_B_SUB,
        ST_SIG,
        ST_DEN_MUL,
        ST_DEN_OUT
    } state_t;

    typedef enum logic [1:0] {
        LAYER_HIDDEN1,
        LAYER_HIDDEN2,
        LAYER_OUTPUT
    } layer_t;

    typedef logic [15:0] sig_table_t [SIG_DEPTH];

    function automatic longint unsigned div_u64(input longint unsigned num,
                                                input longint unsigned dvs);
        longint unsigned q;
        longint unsigned rem;
        q   = 64'd0;
        rem = 64'd0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], num[b]};
            if (rem >= dvs)
            begin
                rem  = rem - dvs;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [15:0] sig_entry(input int k);
        longint          s;
        longint unsigned mag;
        longint unsigned u;
        longint unsigned term;
        longint          acc;
        longint unsigned e;
        longint unsigned den;
        longint unsigned r;
        longint unsigned one;
        one  = 64'd1 << 30;
        s    = 2 * longint'(k) + 1 - longint'(SIG_DEPTH);
        mag  = (s < 0) ? longint'(-s) : longint'(s);
        u    = (mag << 29) / SIG_DEPTH;
        term = one;
        acc  = longint'(one);
        for (int n = 1; n <= 12; n++)
        begin
            term = div_u64((term * u) >> 30, 64'(n));
            if (n % 2 == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        e = (acc < 0) ? 64'd0 : longint'(acc);
        if (e > one)
            e = one;
        for (int n = 0; n < 4; n++)
            e = (e * e + (64'd1 << 29)) >> 30;
        den = one + e;
        if (s >= 0)
            r = div_u64((one << 16) + (den >> 1), den);
        else
            r = div_u64((e << 16) + (den >> 1), den);
        return (r > 64'd65535) ? 16'hFFFF : r[15:0];
    endfunction

    function automatic sig_table_t build_sig_table();
        sig_table_t t;
        for (int k = 0; k < SIG_DEPTH; k++)
            t[k] = sig_entry(k);
        return t;
    endfunction

    localparam sig_table_t SIG_TABLE = build_sig_table();

endpackage

@@ hdl/mlp_window_predictor_core.sv @@
// ----------------------------------------------------------------------------
// mlp_window_predictor_core: fixed-point perceptron series predictor
// Weight memory, sample window and a sequencer around one shared multiplier.
// ----------------------------------------------------------------------------
//  channel  | signals                                         | direction
//  input    | in_valid in_stall kind weight_index weight_value | in (stall out)
//           | sample_value                                    |
//  output   | out_valid out_stall predicted_value             | out (stall in)
//           | normalized_prediction                           |
//  config   | cfg_valid cfg_ready cfg_index cfg_data          | in (ready out)
//
//  Load writes the weight memory while idle. Push runs NORM_MUL, NORM_SAT.
//  Predict runs W_READ, W_MUL, W_ACC per weight, B_READ, B_SUB, SIG per neuron,
//  then DEN_MUL, DEN_OUT. One multiplier; the weight memory read is registered.
//  Reset clears control and the window and presets config; the data registers and
//  weight memory are not cleared. A result waits in the output register while out_stall is high.
// ----------------------------------------------------------------------------
module mlp_window_predictor_core #(
    parameter int WINDOW_LENGTH = 5,
    parameter int HIDDEN_WIDTH  = 5
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      kind,
    input  logic [6:0]                      weight_index,
    input  logic signed [15:0]              weight_value,
    input  logic [15:0]                     sample_value,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [15:0]                     predicted_value,
    output logic [15:0]                     normalized_prediction,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mwp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mwp_pkg::RECIP_W-1:0]     cfg_data
);

    localparam int L1_W      = 0;
    localparam int L1_B      = L1_W + HIDDEN_WIDTH * WINDOW_LENGTH;
    localparam int L2_W      = L1_B + HIDDEN_WIDTH;
    localparam int L2_B      = L2_W + HIDDEN_WIDTH * HIDDEN_WIDTH;
    localparam int OUT_W     = L2_B + HIDDEN_WIDTH;
    localparam int OUT_B     = OUT_W + HIDDEN_WIDTH;
    localparam int MEM_DEPTH = OUT_B + 1;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int MAXN      = (WINDOW_LENGTH > HIDDEN_WIDTH) ? WINDOW_LENGTH : HIDDEN_WIDTH;
    localparam int J_W       = $clog2(MAXN);
    localparam int WIN_W     = $clog2(WINDOW_LENGTH);
    localparam int HID_W     = $clog2(HIDDEN_WIDTH);
    localparam int ACC_W     = mwp_pkg::ACC_W;
    localparam int PROD_W    = mwp_pkg::PROD_W;

    mwp_pkg::state_t state_reg, state_next;
    mwp_pkg::layer_t layer_reg;

    logic [15:0]               min_reg;
    logic [15:0]               span_reg;
    logic [mwp_pkg::RECIP_W-1:0] recip_reg;

    logic [15:0]               window_reg [WINDOW_LENGTH];
    logic [15:0]               h1_reg     [HIDDEN_WIDTH];
    logic [15:0]               h2_reg     [HIDDEN_WIDTH];
    logic [15:0]               wmem       [MEM_DEPTH];
    logic [15:0]               rdata_reg;
    logic [ADDR_W-1:0]         raddr;
    logic [ADDR_W-1:0]         wptr_reg;
    logic [HID_W-1:0]          neuron_reg;
    logic [J_W-1:0]            j_reg;
    logic [15:0]               sample_reg;
    logic [15:0]               y_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [mwp_pkg::MUL_A_W-1:0] mul_a;
    logic signed [mwp_pkg::MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic [15:0]               x_sel;
    logic                      j_last;
    logic                      n_last;
    logic                      slot_free;
    logic                      in_acc;
    logic [15:0]               diff;
    logic signed [ACC_W-1:0]   bias_ext;
    logic signed [ACC_W-1:0]   acc_shift;
    logic [mwp_pkg::SIG_IDX_W-1:0] sig_idx;
    logic [15:0]               sig_val;
    logic [16:0]               den_sum;
    logic                      out_valid_reg;
    logic [15:0]               pred_reg;
    logic [15:0]               norm_reg;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != mwp_pkg::ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign predicted_value       = pred_reg;
    assign normalized_prediction = norm_reg;

    always_comb
    begin
        if (layer_reg == mwp_pkg::LAYER_HIDDEN1)
            j_last = (j_reg == J_W'(WINDOW_LENGTH - 1));
        else
            j_last = (j_reg == J_W'(HIDDEN_WIDTH - 1));
        n_last = (neuron_reg == HID_W'(HIDDEN_WIDTH - 1)) ||
                 (layer_reg == mwp_pkg::LAYER_OUTPUT);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mwp_pkg::ST_IDLE:
            begin
                if (in_acc && kind == mwp_pkg::KIND_PUSH)
                    state_next = mwp_pkg::ST_NORM_MUL;
                else if (in_acc && kind == mwp_pkg::KIND_PREDICT)
                    state_next = mwp_pkg::ST_W_READ;
            end
            mwp_pkg::ST_NORM_MUL: state_next = mwp_pkg::ST_NORM_SAT;
            mwp_pkg::ST_NORM_SAT: state_next = mwp_pkg::ST_IDLE;
            mwp_pkg::ST_W_READ:   state_next = mwp_pkg::ST_W_MUL;
            mwp_pkg::ST_W_MUL:    state_next = mwp_pkg::ST_W_ACC;
            mwp_pkg::ST_W_ACC:    state_next = j_last ? mwp_pkg::ST_B_READ
                                                      : mwp_pkg::ST_W_READ;
            mwp_pkg::ST_B_READ:   state_next = mwp_pkg::ST_B_SUB;
            mwp_pkg::ST_B_SUB:    state_next = mwp_pkg::ST_SIG;
            mwp_pkg::ST_SIG:
            begin
                if (layer_reg == mwp_pkg::LAYER_OUTPUT)
                    state_next = mwp_pkg::ST_DEN_MUL;
                else
                    state_next = mwp_pkg::ST_W_READ;
            end
            mwp_pkg::ST_DEN_MUL:  state_next = mwp_pkg::ST_DEN_OUT;
            mwp_pkg::ST_DEN_OUT:  state_next = slot_free ? mwp_pkg::ST_IDLE
                                                         : mwp_pkg::ST_DEN_OUT;
            default:              state_next = mwp_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        x_sel = 16'd0;
        unique case (layer_reg)
            mwp_pkg::LAYER_HIDDEN1: x_sel = window_reg[j_reg[WIN_W-1:0]];
            mwp_pkg::LAYER_HIDDEN2: x_sel = h1_reg[j_reg[HID_W-1:0]];
            mwp_pkg::LAYER_OUTPUT:  x_sel = h2_reg[j_reg[HID_W-1:0]];
            default:                x_sel = 16'd0;
        endcase

        raddr = wptr_reg;
        if (state_reg == mwp_pkg::ST_B_READ)
        begin
            unique case (layer_reg)
                mwp_pkg::LAYER_HIDDEN1: raddr = ADDR_W'(L1_B) + ADDR_W'(neuron_reg);
                mwp_pkg::LAYER_HIDDEN2: raddr = ADDR_W'(L2_B) + ADDR_W'(neuron_reg);
                mwp_pkg::LAYER_OUTPUT:  raddr = ADDR_W'(OUT_B);
                default:                raddr = wptr_reg;
            endcase
        end

        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            mwp_pkg::ST_NORM_MUL:
            begin
                mul_a = {2'b00, diff};
                mul_b = {1'b0, recip_reg};
            end
            mwp_pkg::ST_W_MUL:
            begin
                mul_a = {{2{rdata_reg[15]}}, rdata_reg};
                mul_b = {18'd0, x_sel};
            end
            mwp_pkg::ST_DEN_MUL:
            begin
                mul_a = {2'b00, y_reg};
                mul_b = {18'd0, span_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign diff      = (sample_reg > min_reg) ? (sample_reg - min_reg) : 16'd0;
    assign mul_p     = mul_a * mul_b;
    assign bias_ext  = {{(ACC_W - 32){rdata_reg[15]}}, rdata_reg, 16'd0};
    assign acc_shift = acc_reg + (ACC_W'(1) <<< 31);
    assign sig_idx   = acc_shift[31:32-mwp_pkg::SIG_IDX_W];
    assign den_sum   = {1'b0, min_reg} + {1'b0, prod_reg[31:16]};

    always_comb
    begin
        if (acc_reg < -(ACC_W'(1) <<< 31))
            sig_val = mwp_pkg::SIG_TABLE[0];
        else if (acc_reg >= (ACC_W'(1) <<< 31))
            sig_val = mwp_pkg::SIG_TABLE[mwp_pkg::SIG_DEPTH-1];
        else
            sig_val = mwp_pkg::SIG_TABLE[sig_idx];
    end

    // weight memory: write on load, registered read every cycle
    always_ff @(posedge clk)
    begin
        if (in_acc && kind == mwp_pkg::KIND_LOAD &&
            {25'd0, weight_index} < 32'(MEM_DEPTH))
            wmem[ADDR_W'(weight_index)] <= weight_value;
        rdata_reg <= wmem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == mwp_pkg::ST_NORM_MUL || state_reg == mwp_pkg::ST_W_MUL ||
            state_reg == mwp_pkg::ST_DEN_MUL)
            prod_reg <= mul_p;
        if (in_acc)
            sample_reg <= sample_value;
        if (state_reg == mwp_pkg::ST_SIG)
        begin
            if (layer_reg == mwp_pkg::LAYER_HIDDEN1)
                h1_reg[neuron_reg] <= sig_val;
            if (layer_reg == mwp_pkg::LAYER_HIDDEN2)
                h2_reg[neuron_reg] <= sig_val;
            if (layer_reg == mwp_pkg::LAYER_OUTPUT)
                y_reg <= sig_val;
        end
        if (state_reg == mwp_pkg::ST_DEN_OUT && slot_free)
        begin
            norm_reg <= y_reg;
            pred_reg <= den_sum[16] ? 16'hFFFF : den_sum[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mwp_pkg::ST_IDLE;
            layer_reg     <= mwp_pkg::LAYER_HIDDEN1;
            min_reg       <= 16'd0;
            span_reg      <= 16'hFFFF;
            recip_reg     <= mwp_pkg::RECIP_W'(65537);
            wptr_reg      <= '0;
            neuron_reg    <= '0;
            j_reg         <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < WINDOW_LENGTH; k++)
                window_reg[k] <= 16'd0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    mwp_pkg::CFG_PRICE_MIN:  min_reg   <= cfg_data[15:0];
                    mwp_pkg::CFG_PRICE_SPAN: span_reg  <= cfg_data[15:0];
                    mwp_pkg::CFG_SPAN_RECIP: recip_reg <= cfg_data;
                    default:                 ;
                endcase
            end

            if (state_reg == mwp_pkg::ST_DEN_OUT && slot_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                mwp_pkg::ST_IDLE:
                begin
                    layer_reg  <= mwp_pkg::LAYER_HIDDEN1;
                    wptr_reg   <= ADDR_W'(L1_W);
                    neuron_reg <= '0;
                    j_reg      <= '0;
                    acc_reg    <= '0;
                end
                mwp_pkg::ST_NORM_SAT:
                begin
                    for (int k = 0; k < WINDOW_LENGTH - 1; k++)
                        window_reg[k] <= window_reg[k+1];
                    window_reg[WINDOW_LENGTH-1] <= (|prod_reg[PROD_W-1:32]) ? 16'hFFFF
                                                                          : prod_reg[31:16];
                end
                mwp_pkg::ST_W_ACC:
                begin
                    acc_reg  <= acc_reg + prod_reg[ACC_W-1:0];
                    wptr_reg <= wptr_reg + ADDR_W'(1);
                    j_reg    <= j_last ? '0 : j_reg + J_W'(1);
                end
                mwp_pkg::ST_B_SUB:
                    acc_reg <= acc_reg - bias_ext;
                mwp_pkg::ST_SIG:
                begin
                    acc_reg <= '0;
                    if (layer_reg == mwp_pkg::LAYER_OUTPUT)
                    begin
                        for (int k = 0; k < WINDOW_LENGTH - 1; k++)
                            window_reg[k] <= window_reg[k+1];
                        window_reg[WINDOW_LENGTH-1] <= sig_val;
                    end
                    else if (n_last)
                    begin
                        neuron_reg <= '0;
                        if (layer_reg == mwp_pkg::LAYER_HIDDEN1)
                        begin
                            layer_reg <= mwp_pkg::LAYER_HIDDEN2;
                            wptr_reg  <= ADDR_W'(L2_W);
                        end
                        else
                        begin
                            layer_reg <= mwp_pkg::LAYER_OUTPUT;
                            wptr_reg  <= ADDR_W'(OUT_W);
                        end
                    end
                    else
                        neuron_reg <= neuron_reg + HID_W'(1);
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == mwp_pkg::ST_DEN_OUT))
        else $error("result raised outside the output step");

    a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mwp_pkg::ST_W_READ && j_reg == '0) |-> (acc_reg == '0))
        else $error("accumulator not cleared at neuron start");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(norm_reg)))
        else $error("stalled result lost");
`endif

endmodule

@@ bench/tb_mlp_window_predictor_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mlp_window_predictor_core: self-checking bench for the window predictor
// Loads weight sets, pushes samples and runs predictions with random gaps and
// output stalls, comparing each prediction with an in-bench fixed-point model.
// ----------------------------------------------------------------------------
module tb_mlp_window_predictor_core;

    localparam int WLEN      = 5;
    localparam int HID       = 5;
    localparam int NWEIGHTS  = 66;
    localparam int L1B       = HID * WLEN;
    localparam int L2W       = L1B + HID;
    localparam int L2B       = L2W + HID * HID;
    localparam int OUTW      = L2B + HID;
    localparam int OUTB      = OUTW + HID;
    localparam int LATENCY   = 260;
    localparam longint CYCLE_LIMIT = 2000000;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic [1:0]                    kind;
    logic [6:0]                    weight_index;
    logic signed [15:0]            weight_value;
    logic [15:0]                   sample_value;
    logic                          out_valid;
    logic                          out_stall;
    logic [15:0]                   predicted_value;
    logic [15:0]                   normalized_prediction;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [mwp_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [mwp_pkg::RECIP_W-1:0]   cfg_data;

    typedef struct packed {
        logic [15:0] denorm;
        logic [15:0] norm;
    } prediction_t;

    prediction_t    pending_predictions[$];
    logic [15:0]    sigmoid_lut[256];
    logic [15:0]    weights[NWEIGHTS];
    logic [15:0]    window[WLEN];
    logic [15:0]    min_reg;
    logic [15:0]    span_reg;
    logic [32:0]    recip_reg;
    int             errors;
    int             predictions_checked;
    int             words_sent;
    longint         cycle_count;
    bit             hold_off;
    int             hold_cycles;

    mlp_window_predictor_core u_dut (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .in_valid              (in_valid),
        .in_stall              (in_stall),
        .kind                  (kind),
        .weight_index          (weight_index),
        .weight_value          (weight_value),
        .sample_value          (sample_value),
        .out_valid             (out_valid),
        .out_stall             (out_stall),
        .predicted_value       (predicted_value),
        .normalized_prediction (normalized_prediction),
        .cfg_valid             (cfg_valid),
        .cfg_ready             (cfg_ready),
        .cfg_index             (cfg_index),
        .cfg_data              (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    function automatic logic [15:0] lut_entry(input int k);
        longint          s;
        longint unsigned mag;
        longint unsigned u;
        longint unsigned term;
        longint          acc;
        longint unsigned e;
        longint unsigned den;
        longint unsigned r;
        longint unsigned q30;
        q30  = 64'd1 << 30;
        s    = 2 * longint'(k) + 1 - 256;
        mag  = (s < 0) ? -s : s;
        u    = (mag << 29) / 256;
        term = q30;
        acc  = q30;
        for (int n = 1; n <= 12; n++)
        begin
            term = ((term * u) >> 30) / n;
            if (n & 1)
                acc -= longint'(term);
            else
                acc += longint'(term);
        end
        e = (acc < 0) ? 0 : acc;
        if (e > q30)
            e = q30;
        for (int n = 0; n < 4; n++)
            e = (e * e + (64'd1 << 29)) >> 30;
        den = q30 + e;
        if (s >= 0)
            r = ((q30 << 16) + den / 2) / den;
        else
            r = ((e << 16) + den / 2) / den;
        return (r > 65535) ? 16'hFFFF : r[15:0];
    endfunction

    function automatic logic [15:0] neuron_out(input int wbase, input int bidx,
                                               input logic [15:0] x[WLEN],
                                               input int count);
        longint acc;
        longint lim;
        longint unsigned idx;
        acc = 0;
        lim = longint'(8) << 28;
        for (int j = 0; j < count; j++)
            acc += longint'($signed(weights[wbase + j])) * longint'(x[j]);
        acc -= longint'($signed(weights[bidx])) * 65536;
        if (acc < -lim)
            return sigmoid_lut[0];
        if (acc >= lim)
            return sigmoid_lut[255];
        idx = (longint'(acc + lim) * 256) >> 32;
        if (idx > 255)
            idx = 255;
        return sigmoid_lut[idx];
    endfunction

    function automatic void shift_window(input logic [15:0] v);
        for (int i = 0; i < WLEN - 1; i++)
            window[i] = window[i + 1];
        window[WLEN - 1] = v;
    endfunction

    function automatic void predict_word(input logic [1:0] k, input logic [6:0] idx,
                                         input logic [15:0] wv, input logic [15:0] sv);
        logic [15:0]     h1[WLEN];
        logic [15:0]     h2[WLEN];
        logic [15:0]     y;
        longint unsigned d;
        longint unsigned v;
        prediction_t     p;
        if (k == mwp_pkg::KIND_LOAD)
        begin
            if (idx < NWEIGHTS)
                weights[idx] = wv;
        end
        else if (k == mwp_pkg::KIND_PUSH)
        begin
            d = (sv > min_reg) ? sv - min_reg : 0;
            v = (d * recip_reg) >> 16;
            shift_window((v > 65535) ? 16'hFFFF : v[15:0]);
        end
        else if (k == mwp_pkg::KIND_PREDICT)
        begin
            h1 = '{default: 0};
            h2 = '{default: 0};
            for (int i = 0; i < HID; i++)
                h1[i] = neuron_out(i * WLEN, L1B + i, window, WLEN);
            for (int i = 0; i < HID; i++)
                h2[i] = neuron_out(L2W + i * HID, L2B + i, h1, HID);
            y = neuron_out(OUTW, OUTB, h2, HID);
            shift_window(y);
            v = longint'(min_reg) + ((longint'(y) * span_reg) >> 16);
            p.denorm = (v > 65535) ? 16'hFFFF : v[15:0];
            p.norm   = y;
            pending_predictions.insert(pending_predictions.size(), p);
        end
    endfunction

    // hold, then release, the output on a pattern
    initial
    begin
        out_stall = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
                out_stall <= 1'b1;
            else
                case (cycle_count[9:8])
                    2'd0: out_stall <= 1'b0;
                    2'd1: out_stall <= ($urandom_range(0, 3) == 0);
                    default: out_stall <= ($urandom_range(0, 1) == 0);
                endcase
        end
    end

    always @(posedge clk)
    begin
        prediction_t exp_p;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_predictions.size() == 0)
            begin
                $error("unexpected prediction word: %0d/%0d",
                       predicted_value, normalized_prediction);
                errors++;
            end
            else
            begin
                exp_p = pending_predictions.pop_front();
                predictions_checked++;
                if (predicted_value !== exp_p.denorm)
                begin
                    $error("predicted_value: expected %0d, got %0d",
                           exp_p.denorm, predicted_value);
                    errors++;
                end
                if (normalized_prediction !== exp_p.norm)
                begin
                    $error("normalized_prediction: expected %0d, got %0d",
                           exp_p.norm, normalized_prediction);
                    errors++;
                end
            end
        end
    end

    task automatic send_word(input logic [1:0] k, input logic [6:0] idx,
                             input logic [15:0] wv, input logic [15:0] sv);
        in_valid     <= 1'b1;
        kind         <= k;
        weight_index <= idx;
        weight_value <= wv;
        sample_value <= sv;
        do
            @(posedge clk);
        while (in_stall);
        predict_word(k, idx, wv, sv);
        words_sent++;
        // drop valid for a random gap between bursts
        if ($urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic go_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_predictions.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic write_reg(input logic [mwp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [32:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == mwp_pkg::CFG_PRICE_MIN)
            min_reg = val[15:0];
        else if (idx == mwp_pkg::CFG_PRICE_SPAN)
            span_reg = val[15:0];
        else if (idx == mwp_pkg::CFG_SPAN_RECIP)
            recip_reg = val;
        @(posedge clk);
    endtask

    task automatic set_range(input logic [15:0] lo, input logic [15:0] span,
                             input logic [32:0] recip);
        go_idle();
        write_reg(mwp_pkg::CFG_PRICE_MIN, 33'(lo));
        write_reg(mwp_pkg::CFG_PRICE_SPAN, 33'(span));
        write_reg(mwp_pkg::CFG_SPAN_RECIP, recip);
    endtask

    function automatic logic [32:0] recip_of(input logic [15:0] span);
        return 33'(((longint'(1) << 32) + span / 2) / span);
    endfunction

    // scale sets how wide the random weights spread
    task automatic load_all_weights(input int scale);
        for (int i = 0; i < NWEIGHTS; i++)
            send_word(mwp_pkg::KIND_LOAD, 7'(i),
                      16'($urandom_range(0, 2 * scale) - scale), 16'($urandom));
    endtask

    task automatic test_directed();
        for (int i = 0; i < NWEIGHTS; i++)
            send_word(mwp_pkg::KIND_LOAD, 7'(i), 16'sd0, 16'h0000);
        send_word(mwp_pkg::KIND_PREDICT, 7'h7F, 16'hFFFF, 16'hFFFF);
        send_word(mwp_pkg::KIND_PUSH, 7'd0, 16'h0000, 16'hFFFF);
        send_word(mwp_pkg::KIND_PUSH, 7'h7F, 16'hFFFF, 16'h0000);
        send_word(mwp_pkg::KIND_LOAD, 7'd66, 16'h7FFF, 16'h0000);
        send_word(mwp_pkg::KIND_LOAD, 7'h7F, 16'h7FFF, 16'h0000);
        send_word(mwp_pkg::KIND_UNUSED, 7'h55, 16'h5555, 16'hAAAA);
        send_word(mwp_pkg::KIND_LOAD, 7'd0, 16'h7FFF, 16'h0000);
        send_word(mwp_pkg::KIND_LOAD, 7'(OUTW), 16'h8000, 16'h0000);
        send_word(mwp_pkg::KIND_LOAD, 7'(OUTB), 16'h8000, 16'h0000);
        send_word(mwp_pkg::KIND_PREDICT, 7'd0, 16'h0000, 16'h0000);
        send_word(mwp_pkg::KIND_LOAD, 7'(OUTB), 16'h7FFF, 16'h0000);
        send_word(mwp_pkg::KIND_PREDICT, 7'd0, 16'h0000, 16'h0000);
        send_word(mwp_pkg::KIND_LOAD, 7'(OUTB), 16'h0000, 16'h0000);
        send_word(mwp_pkg::KIND_PREDICT, 7'h2A, 16'h1234, 16'h5678);
    endtask

    task automatic test_random_series(input int words, input int scale);
        int r;
        load_all_weights(scale);
        for (int n = 0; n < words; n++)
        begin
            r = $urandom_range(0, 19);
            if (r < 11)
                send_word(mwp_pkg::KIND_PUSH, 7'($urandom), 16'($urandom),
                          16'($urandom));
            else if (r < 17)
                send_word(mwp_pkg::KIND_PREDICT, 7'($urandom), 16'($urandom),
                          16'($urandom));
            else if (r < 19)
                send_word(mwp_pkg::KIND_LOAD, 7'($urandom_range(0, 127)),
                          16'($urandom), 16'($urandom));
            else
                send_word(mwp_pkg::KIND_UNUSED, 7'($urandom), 16'($urandom),
                          16'($urandom));
        end
    endtask

    task automatic test_backpressure();
        hold_off    = 1'b1;
        hold_cycles = 0;
        fork
            begin
                for (int n = 0; n < 6; n++)
                    send_word(mwp_pkg::KIND_PREDICT, 7'd0, 16'd0, 16'($urandom));
            end
            begin
                while (hold_cycles < 3000)
                begin
                    @(posedge clk);
                    hold_cycles++;
                end
                hold_off = 1'b0;
            end
        join
    endtask

    initial
    begin
        errors              = 0;
        predictions_checked = 0;
        words_sent          = 0;
        hold_off            = 1'b0;
        rst_n               = 1'b0;
        in_valid            = 1'b0;
        kind                = mwp_pkg::KIND_LOAD;
        weight_index        = '0;
        weight_value        = '0;
        sample_value        = '0;
        cfg_valid           = 1'b0;
        cfg_index           = mwp_pkg::CFG_PRICE_MIN;
        cfg_data            = '0;
        min_reg             = 16'd0;
        span_reg            = 16'hFFFF;
        recip_reg           = 33'd65537;
        window              = '{default: 0};
        weights             = '{default: 0};
        for (int k = 0; k < 256; k++)
            sigmoid_lut[k] = lut_entry(k);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        set_range(16'd0, 16'd1, 33'h1_0000_0000);
        test_random_series(30, 4096);
        set_range(16'hFFFF, 16'hFFFF, 33'd65536);
        test_random_series(20, 32768);
        set_range(16'd1000, 16'd3000, recip_of(16'd3000));
        test_random_series(25, 1024);
        set_range(16'd30000, 16'd20000, recip_of(16'd20000));
        test_random_series(25, 16384);
        test_backpressure();

        go_idle();
        $display("Sent %0d words over five range settings; checked %0d predictions.",
                 words_sent, predictions_checked);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/mwp_pkg.sv
hdl/mlp_window_predictor_core.sv
bench/tb_mlp_window_predictor_core.sv
